@@ rtl/utdt_pkg.sv @@
// ============================================================================
// UTF-8 delimiter tokenizer package
// Shared result types, result kind codes, configuration indexes and the
// fixed table of wide punctuation delimiters.
// ============================================================================
`default_nettype none

package utdt_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TERM_BYTE    = 3'd0,
        KIND_TERM_END     = 3'd1,
        KIND_INVALID_LEAD = 3'd2,
        KIND_DOC_END      = 3'd3,
        KIND_TRUNCATED    = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HIGH = 1'b1;

    localparam logic [63:0] MAP_LOW_RESET  = 64'd15852952090306413568;
    localparam logic [63:0] MAP_HIGH_RESET = 64'd8646911286296182785;

    // Most results one input byte can cause: four term bytes, term end, doc end
    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned COUNT_W     = 3;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] items;
        logic [COUNT_W-1:0]     count;
    } res_list_t;

    // Wide delimiter table: sequence length and its first three bytes
    typedef struct packed {
        logic [2:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } wide_t;

    localparam int unsigned WIDE_TABLE_SIZE     = 20;
    localparam int unsigned NUM_WIDE_DELIMITERS = 20;
    localparam int unsigned WIDE_USED =
        (NUM_WIDE_DELIMITERS < WIDE_TABLE_SIZE) ? NUM_WIDE_DELIMITERS : WIDE_TABLE_SIZE;

    localparam wide_t WIDE_TABLE [WIDE_TABLE_SIZE] = '{
        '{3'd3, 8'hEF, 8'hBC, 8'h8C}, '{3'd3, 8'hE3, 8'h80, 8'h82},
        '{3'd3, 8'hEF, 8'hBC, 8'h88}, '{3'd3, 8'hEF, 8'hBC, 8'h89},
        '{3'd2, 8'hC2, 8'hB7, 8'h00}, '{3'd3, 8'hEF, 8'hBD, 8'h9E},
        '{3'd3, 8'hEF, 8'hBC, 8'h9F}, '{3'd3, 8'hE3, 8'h80, 8'h8B},
        '{3'd3, 8'hE3, 8'h80, 8'h8A}, '{3'd3, 8'hEF, 8'hBD, 8'h9C},
        '{3'd3, 8'hE3, 8'h80, 8'h81}, '{3'd3, 8'hEF, 8'hBC, 8'h9B},
        '{3'd3, 8'hEF, 8'hBC, 8'h9A}, '{3'd2, 8'hC2, 8'hB7, 8'h00},
        '{3'd3, 8'hE3, 8'h80, 8'h8C}, '{3'd3, 8'hE3, 8'h80, 8'h8D},
        '{3'd3, 8'hE3, 8'h80, 8'h90}, '{3'd3, 8'hE3, 8'h80, 8'h91},
        '{3'd3, 8'hE2, 8'h80, 8'h9C}, '{3'd3, 8'hE2, 8'h80, 8'h99}
    };

endpackage

`default_nettype wire

@@ rtl/utdt_front.sv @@
// ============================================================================
// Tokenizer front end
// Holds the sequence and term state and turns one input byte into the
// ordered list of results it causes.
// ============================================================================
`default_nettype none

module utdt_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         in_byte,
    input  wire logic               doc_end,
    input  wire logic [63:0]        map_low,
    input  wire logic [63:0]        map_high,
    output utdt_pkg::res_list_t     list
);

    localparam int unsigned NCAND = 8;

    logic [7:0] buf_reg [4];
    logic [2:0] seq_len_reg, seq_len_next;
    logic [2:0] seq_cnt_reg, seq_cnt_next;
    logic       term_open_reg, term_open_next;

    logic [7:0]           eff [4];
    logic                 seq_open;
    logic                 complete;
    logic                 wide_hit;
    logic                 is_ascii;
    logic                 is_delim;
    logic [2:0]           lead_len;
    logic                 invalid_lead;
    logic                 plain_done;
    logic                 body_close;
    logic [2:0]           seq_len_mid;
    logic                 term_mid;
    logic [NCAND-1:0]     cand_valid;
    utdt_pkg::res_t       cand [NCAND];
    logic [utdt_pkg::COUNT_W-1:0] n;

    assign seq_open = (seq_len_reg != 3'd0);
    assign is_ascii = !seq_open && !in_byte[7];
    assign is_delim = in_byte[6] ? map_high[in_byte[5:0]] : map_low[in_byte[5:0]];

    always_comb
    begin
        if (in_byte[7:4] == 4'hF)
            lead_len = 3'd4;
        else if (in_byte[7:5] == 3'h7)
            lead_len = 3'd3;
        else if (in_byte[7:6] == 2'h3)
            lead_len = 3'd2;
        else
            lead_len = 3'd0;
    end

    assign invalid_lead = !seq_open && in_byte[7] && (lead_len == 3'd0);

    // Sequence bytes with the incoming byte dropped into its slot
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            eff[k] = (seq_cnt_reg[1:0] == 2'(k)) ? in_byte : buf_reg[k];
    end

    assign complete = seq_open && ((seq_cnt_reg + 3'd1) >= seq_len_reg);

    always_comb
    begin
        wide_hit = 1'b0;
        for (int i = 0; i < utdt_pkg::WIDE_USED; i++)
        begin
            if (utdt_pkg::WIDE_TABLE[i].len == seq_len_reg &&
                utdt_pkg::WIDE_TABLE[i].b0 == eff[0] &&
                utdt_pkg::WIDE_TABLE[i].b1 == eff[1] &&
                (utdt_pkg::WIDE_TABLE[i].len < 3'd3 || utdt_pkg::WIDE_TABLE[i].b2 == eff[2]))
                wide_hit = 1'b1;
        end
    end

    assign plain_done = complete && !wide_hit;
    assign body_close = ((complete && wide_hit) || (is_ascii && is_delim)) && term_open_reg;

    // State after the byte itself, before document end handling
    always_comb
    begin
        if (complete)
            seq_len_mid = 3'd0;
        else if (!seq_open && in_byte[7])
            seq_len_mid = lead_len;
        else
            seq_len_mid = seq_len_reg;

        if (complete)
            term_mid = !wide_hit;
        else if (is_ascii)
            term_mid = !is_delim;
        else
            term_mid = term_open_reg;
    end

    always_comb
    begin
        seq_len_next   = doc_end ? 3'd0 : seq_len_mid;
        term_open_next = doc_end ? 1'b0 : term_mid;
        if (doc_end || complete)
            seq_cnt_next = 3'd0;
        else if (seq_open)
            seq_cnt_next = seq_cnt_reg + 3'd1;
        else if (in_byte[7] && lead_len != 3'd0)
            seq_cnt_next = 3'd1;
        else
            seq_cnt_next = seq_cnt_reg;
    end

    // Candidate results in output order, then compact the valid ones
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cand_valid[k] = plain_done && (3'(k) < seq_len_reg);
            cand[k].kind  = utdt_pkg::KIND_TERM_BYTE;
            cand[k].data  = eff[k];
        end
        cand_valid[0] = plain_done || (is_ascii && !is_delim);
        cand[0].data  = is_ascii ? in_byte : eff[0];

        cand_valid[4] = invalid_lead || body_close;
        cand[4].kind  = invalid_lead ? utdt_pkg::KIND_INVALID_LEAD : utdt_pkg::KIND_TERM_END;
        cand[4].data  = 8'd0;

        cand_valid[5] = doc_end && (seq_len_mid != 3'd0);
        cand[5].kind  = utdt_pkg::KIND_TRUNCATED;
        cand[5].data  = 8'd0;

        cand_valid[6] = doc_end && term_mid;
        cand[6].kind  = utdt_pkg::KIND_TERM_END;
        cand[6].data  = 8'd0;

        cand_valid[7] = doc_end;
        cand[7].kind  = utdt_pkg::KIND_DOC_END;
        cand[7].data  = 8'd0;
    end

    always_comb
    begin
        n = '0;
        list.items = '0;
        for (int c = 0; c < NCAND; c++)
        begin
            if (cand_valid[c] && n < utdt_pkg::COUNT_W'(utdt_pkg::MAX_RESULTS))
            begin
                list.items[n] = cand[c];
                n = n + 1'b1;
            end
        end
        list.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg   <= 3'd0;
            seq_cnt_reg   <= 3'd0;
            term_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            seq_len_reg   <= seq_len_next;
            seq_cnt_reg   <= seq_cnt_next;
            term_open_reg <= term_open_next;
        end
    end

    // Sequence bytes carry no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (seq_open)
                buf_reg[seq_cnt_reg[1:0]] <= in_byte;
            else if (in_byte[7])
                buf_reg[0] <= in_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/utdt_queue.sv @@
// ============================================================================
// Tokenizer result register
// Holds the results of one input byte and hands them out one per cycle while out_ready is high.
// ============================================================================
`default_nettype none

module utdt_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire utdt_pkg::res_list_t list,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output utdt_pkg::res_t          out_res,
    output logic                    out_last
);

    utdt_pkg::res_t                items_reg [utdt_pkg::MAX_RESULTS];
    logic [utdt_pkg::COUNT_W-1:0]  count_reg;
    logic [utdt_pkg::COUNT_W-1:0]  idx_reg;
    logic                          pop;
    logic                          load;

    assign out_valid = (count_reg != '0);
    assign out_last  = ((idx_reg + 1'b1) == count_reg);
    assign out_res   = items_reg[idx_reg];
    assign pop       = out_valid && out_ready;
    // Take a new request as the last waiting result leaves
    assign in_ready  = !out_valid || (pop && out_last);
    assign load      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            count_reg <= list.count;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            if (out_last)
            begin
                count_reg <= '0;
                idx_reg   <= '0;
            end
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < utdt_pkg::MAX_RESULTS; i++)
                items_reg[i] <= list.items[i];
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf8_delimiter_tokenizer.sv @@
// ============================================================================
// UTF-8 delimiter tokenizer
// Splits a UTF-8 byte stream into term bytes, term ends, invalid-lead and truncation results and document ends.
// ============================================================================
// The first result of a request appears in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result
//   and m_tready is high; a byte with more results holds the input until the
//   single result port drains the result register, one entry per ready cycle.
// Reset (rst_n low, asynchronous): no sequence or term open, result register
//   empty, delimiter maps back to their defaults; sequence bytes uncleared.
`default_nettype none

module utf8_delimiter_tokenizer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] in_byte
    input  wire logic                             s_tlast,   // doc_end
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,   // [7:0] out_byte
    output logic [2:0]                            m_tuser,   // [2:0] kind
    output logic                                  m_tlast,   // run_last
    // Configuration
    input  wire logic                             cfg_we,
    input  wire logic [utdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]                      cfg_data
);

    logic [63:0]         map_low_reg;
    logic [63:0]         map_high_reg;
    logic                accept;
    utdt_pkg::res_list_t list;
    utdt_pkg::res_t      out_res;

    // Delimiter map: one bit per ASCII code, low half codes 0..63
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_low_reg  <= utdt_pkg::MAP_LOW_RESET;
            map_high_reg <= utdt_pkg::MAP_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                utdt_pkg::CFG_MAP_LOW:  map_low_reg  <= cfg_data;
                utdt_pkg::CFG_MAP_HIGH: map_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A request is taken when the result register is empty or frees up this cycle
    assign accept = s_tvalid && s_tready;

    // Classify the byte, advance sequence and term state, build results
    utdt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (s_tdata),
        .doc_end  (s_tlast),
        .map_low  (map_low_reg),
        .map_high (map_high_reg),
        .list     (list)
    );

    // Hold the results and drain them one per cycle while m_tready is high; a
    // byte with no results simply leaves the register empty
    utdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .list      (list),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    assign m_tdata = out_res.data;
    assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

@@ rtl/utdt_checker.sv @@
// ============================================================================
// Tokenizer port checker
// Watches the result stream of the tokenizer for illegal result patterns.
// ============================================================================
`default_nettype none

module utdt_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic [2:0] m_tuser,
    input  wire logic       m_tlast
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Only term bytes carry data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != 3'(utdt_pkg::KIND_TERM_BYTE)) |-> m_tdata == 8'd0)
        else $error("non-byte result with nonzero data");

    // Document end is always the last result of its request
    a_doc_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == 3'(utdt_pkg::KIND_DOC_END)) |-> m_tlast)
        else $error("document end not last");

    // Invalid lead result is followed, within its byte, only by a term end or document end
    a_invalid_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == 3'(utdt_pkg::KIND_INVALID_LEAD)) && !m_tlast
        |=> m_tvalid && (m_tuser == 3'(utdt_pkg::KIND_DOC_END) ||
                         m_tuser == 3'(utdt_pkg::KIND_TERM_END)))
        else $error("invalid lead followed by wrong result");

endmodule

bind utf8_delimiter_tokenizer utdt_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
